/* hw/rtl/dstq_pkg.sv */
`default_nettype none
package dstq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ID_W  = 32;
  localparam int unsigned DL_W  = 64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } state_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic            cmp_en;
    logic            ins_en;
    logic            del_en;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/dstq_cell.sv */
`default_nettype none
module dstq_cell
  import dstq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire cell_cmd_t       cmd_i,
  input  wire logic            occ_i,
  input  wire logic            left_lo_i,
  input  wire logic [ID_W-1:0] left_id_i,
  input  wire logic [DL_W-1:0] left_dl_i,
  input  wire logic [ID_W-1:0] right_id_i,
  input  wire logic [DL_W-1:0] right_dl_i,
  input  wire logic            hit_i,
  output logic                 hit_o,
  output logic                 lo_o,
  output logic [ID_W-1:0]      id_o,
  output logic [DL_W-1:0]      dl_o,
  output logic [ID_W-1:0]      sel_id_o,
  output logic [DL_W-1:0]      sel_dl_o
);

  logic [ID_W-1:0] id_q, id_d;
  logic [DL_W-1:0] dl_q, dl_d;
  logic            le_q, match_q;
  logic            first;

  assign lo_o  = le_q & occ_i;
  assign hit_o = hit_i | (match_q & occ_i);
  assign first = match_q & occ_i & ~hit_i;

  assign id_o     = id_q;
  assign dl_o     = dl_q;
  assign sel_id_o = first ? id_q : '0;
  assign sel_dl_o = first ? dl_q : '0;

  always_comb begin
    id_d = id_q;
    dl_d = dl_q;
    if (cmd_i.ins_en) begin
      if (!left_lo_i) begin
        // past the insert point: shift right by one
        id_d = left_id_i;
        dl_d = left_dl_i;
      end else if (!lo_o) begin
        id_d = cmd_i.id;
        dl_d = cmd_i.dl;
      end
    end else if (cmd_i.del_en && hit_o) begin
      // at or past the removed task: pull from the right
      id_d = right_id_i;
      dl_d = right_dl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
    if (cmd_i.cmp_en) begin
      le_q    <= (dl_q <= cmd_i.dl);
      match_q <= (id_q == cmd_i.id);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/deadline_sorted_task_queue.sv */
// Deadline-sorted task queue, earliest deadline at the head.
//
// Input channel (in_valid_i / in_ready_o) carries one command per beat:
// action_i selects insert, delete by id or look up by id; task_id_i names
// the task and deadline_i gives its deadline for an insert. Output channel
// (out_valid_o / out_ready_i) returns one result beat per command with the
// status, the affected task, the count after the command and the head.
//
// Tasks live in a row of DEPTH cells, each holding one id and deadline.
// After accept, in the compare state every cell compares its own entry
// against the command in parallel; in the update state that follows, each
// cell loads from its left or right neighbor, from the command, or holds,
// which shifts the row open for an insert or closed for a delete. The
// result is registered and held in the output state until taken. One
// command is in flight at a time: in_ready_o is low from accept until the
// result beat is taken, so a stalled receiver simply holds the block.
// Reset empties the queue at once (count zero); the cell contents need no
// clearing.
`default_nettype none
module deadline_sorted_task_queue
  import dstq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [ID_W-1:0]  task_id_i,
  input  wire logic [DL_W-1:0]  deadline_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            status_o,
  output logic [ID_W-1:0]       found_id_o,
  output logic [DL_W-1:0]       found_deadline_o,
  output logic [CNT_W-1:0]      entry_count_o,
  output logic [ID_W-1:0]       head_id_o,
  output logic [DL_W-1:0]       head_deadline_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       act_q;
  logic [ID_W-1:0]  cid_q;
  logic [DL_W-1:0]  cdl_q;
  logic [1:0]       status_q, status_d;
  logic [ID_W-1:0]  fid_q, fid_d;
  logic [DL_W-1:0]  fdl_q, fdl_d;

  cell_cmd_t       cmd;
  logic            full, hit_any;
  logic [ID_W-1:0] mux_id;
  logic [DL_W-1:0] mux_dl;

  logic [DEPTH-1:0] occ, lo;
  logic [DEPTH:0]   hit;
  logic [ID_W-1:0]  cell_id [DEPTH];
  logic [DL_W-1:0]  cell_dl [DEPTH];
  logic [ID_W-1:0]  sel_id  [DEPTH];
  logic [DL_W-1:0]  sel_dl  [DEPTH];

  assign full    = (count_q == CNT_W'(DEPTH));
  assign hit_any = hit[DEPTH];
  assign hit[0]  = 1'b0;

  assign cmd.cmp_en = (state_q == S_CMP);
  assign cmd.ins_en = (state_q == S_UPD) && (act_q == ACT_INSERT) && !full;
  assign cmd.del_en = (state_q == S_UPD) && (act_q == ACT_DELETE) && hit_any;
  assign cmd.id     = cid_q;
  assign cmd.dl     = cdl_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            left_lo;
    logic [ID_W-1:0] left_id, right_id;
    logic [DL_W-1:0] left_dl, right_dl;

    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_lo = 1'b1;
      assign left_id = cell_id[i];
      assign left_dl = cell_dl[i];
    end else begin : g_mid
      assign left_lo = lo[i-1];
      assign left_id = cell_id[i-1];
      assign left_dl = cell_dl[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_id = cell_id[i];
      assign right_dl = cell_dl[i];
    end else begin : g_inner
      assign right_id = cell_id[i+1];
      assign right_dl = cell_dl[i+1];
    end

    dstq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (occ[i]),
      .left_lo_i  (left_lo),
      .left_id_i  (left_id),
      .left_dl_i  (left_dl),
      .right_id_i (right_id),
      .right_dl_i (right_dl),
      .hit_i      (hit[i]),
      .hit_o      (hit[i+1]),
      .lo_o       (lo[i]),
      .id_o       (cell_id[i]),
      .dl_o       (cell_dl[i]),
      .sel_id_o   (sel_id[i]),
      .sel_dl_o   (sel_dl[i])
    );
  end

  // at most one cell drives a nonzero select
  always_comb begin
    mux_id = '0;
    mux_dl = '0;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      mux_id = mux_id | sel_id[k];
      mux_dl = mux_dl | sel_dl[k];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    status_d = status_q;
    fid_d    = fid_q;
    fdl_d    = fdl_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        state_d  = S_OUT;
        status_d = STAT_OK;
        fid_d    = '0;
        fdl_d    = '0;
        case (act_q) inside
          ACT_INSERT: begin
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              fid_d   = cid_q;
              fdl_d   = cdl_q;
              count_d = count_q + CNT_W'(1);
            end
          end
          ACT_DELETE, ACT_LOOKUP: begin
            if (!hit_any) begin
              status_d = STAT_NOTFOUND;
            end else begin
              fid_d = mux_id;
              fdl_d = mux_dl;
              if (act_q == ACT_DELETE) count_d = count_q - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q <= action_i;
      cid_q <= task_id_i;
      cdl_q <= deadline_i;
    end
    status_q <= status_d;
    fid_q    <= fid_d;
    fdl_q    <= fdl_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = (state_q == S_OUT);
  assign status_o         = status_q;
  assign found_id_o       = fid_q;
  assign found_deadline_o = fdl_q;
  assign entry_count_o    = count_q;
  assign head_id_o        = occ[0] ? cell_id[0] : '0;
  assign head_deadline_o  = occ[0] ? cell_dl[0] : '0;

endmodule
`default_nettype wire

/* hw/rtl/dstq_checker.sv */
`default_nettype none
module dstq_checker
  import dstq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_o,
  input  wire logic             out_valid_o,
  input  wire logic             out_ready_i,
  input  wire logic [1:0]       status_o,
  input  wire logic [ID_W-1:0]  found_id_o,
  input  wire logic [DL_W-1:0]  found_deadline_o,
  input  wire logic [CNT_W-1:0] entry_count_o,
  input  wire logic [ID_W-1:0]  head_id_o,
  input  wire logic [DL_W-1:0]  head_deadline_o
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(found_id_o) && $stable(found_deadline_o))
    else $error("result beat changed while stalled");

  // one command in flight: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 out_valid_o)
    else $error("result not on time after accept");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |->
      entry_count_o == CNT_W'(DEPTH) && found_id_o == '0)
    else $error("full status with room left");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o == '0 |-> head_id_o == '0 && head_deadline_o == '0)
    else $error("head nonzero while empty");

endmodule

bind deadline_sorted_task_queue dstq_checker u_dstq_checker (.*);
`default_nettype wire

/* dv/deadline_sorted_task_queue_tb.sv */
`default_nettype none
module deadline_sorted_task_queue_tb;
  import dstq_pkg::*;

  localparam logic [1:0]  ACT_UNUSED       = 2'd3;
  localparam int          RANDOM_ITEMS     = 1400;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES     = 16;
  localparam int          CYCLE_LIMIT      = 500000;
  localparam int          REPORT_LIMIT     = 10;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  found_id;
    logic [DL_W-1:0]  found_dl;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
    logic [DL_W-1:0]  head_dl;
  } result_t;

  // Sorted-store predictor and expected-result checker.
  class task_queue_scoreboard;
    logic [ID_W-1:0] slot_ids [DEPTH];
    logic [DL_W-1:0] slot_dls [DEPTH];
    int              held;
    int              peak_held;
    result_t         expected_results_q [$];
    int unsigned     fail_count;
    int unsigned     beats_checked;
    int unsigned     full_hits;
    int unsigned     absent_hits;
    int unsigned     cmd_count [4];

    function void note_command(input logic [1:0] act, input logic [ID_W-1:0] id,
                               input logic [DL_W-1:0] dl);
      result_t r;
      int      pos;
      r = '0;
      cmd_count[act]++;
      case (act)
        ACT_INSERT: begin
          if (held >= DEPTH) begin
            r.status = STAT_FULL;
            full_hits++;
          end else begin
            pos = 0;
            // equal deadlines stay first in, first out
            while (pos < held && slot_dls[pos] <= dl) pos++;
            for (int i = held; i > pos; i--) begin
              slot_ids[i] = slot_ids[i-1];
              slot_dls[i] = slot_dls[i-1];
            end
            slot_ids[pos] = id;
            slot_dls[pos] = dl;
            held++;
            r.found_id = id;
            r.found_dl = dl;
          end
        end
        ACT_DELETE, ACT_LOOKUP: begin
          pos = 0;
          while (pos < held && slot_ids[pos] != id) pos++;
          if (pos == held) begin
            r.status = STAT_NOTFOUND;
            absent_hits++;
          end else begin
            r.found_id = slot_ids[pos];
            r.found_dl = slot_dls[pos];
            if (act == ACT_DELETE) begin
              for (int i = pos; i + 1 < held; i++) begin
                slot_ids[i] = slot_ids[i+1];
                slot_dls[i] = slot_dls[i+1];
              end
              held--;
            end
          end
        end
        default: ;
      endcase
      if (held > peak_held) peak_held = held;
      r.count = held[CNT_W-1:0];
      if (held > 0) begin
        r.head_id = slot_ids[0];
        r.head_dl = slot_dls[0];
      end
      expected_results_q.push_back(r);
    endfunction

    function void check_field(input string name, input logic [DL_W-1:0] want,
                              input logic [DL_W-1:0] got);
      if (got === want) return;
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("mismatch in result beat %0d, %s: expected %0h, got %0h",
                 beats_checked, name, want, got);
    endfunction

    function void check_result_beat(input result_t got);
      result_t want;
      beats_checked++;
      if (expected_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("result beat %0d arrived with nothing pending: %h", beats_checked, got);
        return;
      end
      want = expected_results_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("found_id", want.found_id, got.found_id);
      check_field("found_deadline", want.found_dl, got.found_dl);
      check_field("entry_count", want.count, got.count);
      check_field("head_id", want.head_id, got.head_id);
      check_field("head_deadline", want.head_dl, got.head_dl);
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [1:0]       action_i    = ACT_INSERT;
  logic [ID_W-1:0]  task_id_i   = '0;
  logic [DL_W-1:0]  deadline_i  = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [1:0]       status_o;
  logic [ID_W-1:0]  found_id_o;
  logic [DL_W-1:0]  found_deadline_o;
  logic [CNT_W-1:0] entry_count_o;
  logic [ID_W-1:0]  head_id_o;
  logic [DL_W-1:0]  head_deadline_o;

  task_queue_scoreboard sb;
  int                   cycles = 0;

  deadline_sorted_task_queue DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .task_id_i        (task_id_i),
    .deadline_i       (deadline_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_id_o       (found_id_o),
    .found_deadline_o (found_deadline_o),
    .entry_count_o    (entry_count_o),
    .head_id_o        (head_id_o),
    .head_deadline_o  (head_deadline_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles,
             sb.expected_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one command and hold it until the beat is taken.
  task automatic send_command(input logic [1:0] act, input logic [ID_W-1:0] id,
                              input logic [DL_W-1:0] dl);
    in_valid_i <= 1'b1;
    action_i   <= act;
    task_id_i  <= id;
    deadline_i <= dl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_command(act, id, dl);
  endtask

  task automatic idle_sender(input int gap);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] held_id();
    return sb.slot_ids[$urandom_range(0, sb.held - 1)];
  endfunction

  function automatic logic [DL_W-1:0] random_deadline();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      // small pool so equal deadlines collide often
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return '1;
        2:       return 64'h8000_0000_0000_0000;
        3:       return 64'h7FFF_FFFF_FFFF_FFFF;
        default: return 64'd1000 + $urandom_range(0, 2);
      endcase
    end
    if (roll < 42 && sb.held > 0) return sb.slot_dls[$urandom_range(0, sb.held - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic void pick_command(input bit filling, output logic [1:0] act,
                                       output logic [ID_W-1:0] id,
                                       output logic [DL_W-1:0] dl);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)                         act = ACT_UNUSED;
    else if (roll < (filling ? 64 : 30))  act = ACT_INSERT;
    else if (roll < (filling ? 82 : 76))  act = ACT_DELETE;
    else                                  act = ACT_LOOKUP;
    dl   = random_deadline();
    roll = $urandom_range(0, 99);
    if (act == ACT_INSERT) begin
      if (roll < 65)                      id = $urandom;
      else if (roll < 88 || sb.held == 0) id = $urandom_range(0, 7);
      else                                id = held_id();
    end else begin
      if (roll < 78 && sb.held > 0)       id = held_id();
      else if (roll < 89)                 id = $urandom_range(0, 7);
      else                                id = $urandom;
    end
  endfunction

  // Receiver: segments of random stall modes plus two long hold-offs.
  initial begin
    int seg_left;
    int mode;
    int long_holds;
    seg_left   = 0;
    mode       = 0;
    long_holds = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 60);
      end
      seg_left--;
      if (long_holds < 2 && sb.beats_checked >= (long_holds == 0 ? 200 : 900)) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_holds++;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result_beat({status_o, found_id_o, found_deadline_o, entry_count_o,
                            head_id_o, head_deadline_o});
  end

  initial begin
    logic [1:0]      act;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
    int              sent;
    int              burst;
    bit              filling;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: absent ids and the unused action
    send_command(ACT_LOOKUP, '0, '0);
    send_command(ACT_DELETE, '1, '1);
    send_command(ACT_UNUSED, '1, '1);
    // extremes, equal deadlines and a duplicate id
    send_command(ACT_INSERT, '1, '1);
    send_command(ACT_INSERT, '0, '0);
    send_command(ACT_INSERT, 32'd5, 64'd100);
    send_command(ACT_INSERT, 32'd6, 64'd100);
    send_command(ACT_INSERT, 32'd5, 64'd50);
    send_command(ACT_LOOKUP, 32'd5, '1);
    send_command(ACT_DELETE, 32'd5, '0);
    send_command(ACT_DELETE, '0, 64'hA5A5_5A5A_0F0F_F0F0);
    // fill up, then one insert too many
    for (int k = 0; k < 13; k++) send_command(ACT_INSERT, 32'h100 + k, {$urandom, $urandom});
    send_command(ACT_INSERT, 32'hDEAD_BEEF, 64'd7);

    sent    = 0;
    filling = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) begin
        pick_command(filling, act, id, dl);
        send_command(act, id, dl);
        if (act != ACT_UNUSED) sent++;
        // sweep the occupancy between empty and full
        if (sb.held == DEPTH)                filling = 1'b0;
        else if (sb.held == 0)               filling = 1'b1;
        else if ($urandom_range(0, 49) == 0) filling = !filling;
      end
      idle_sender($urandom_range(1, 10));
    end

    in_valid_i <= 1'b0;
    while (sb.expected_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d inserts, %0d deletes, %0d look-ups, %0d unused commands;",
             sb.cmd_count[ACT_INSERT], sb.cmd_count[ACT_DELETE],
             sb.cmd_count[ACT_LOOKUP], sb.cmd_count[ACT_UNUSED]);
    $display("store full %0d times, id absent %0d times, peak %0d of %0d, %0d beats checked.",
             sb.full_hits, sb.absent_hits, sb.peak_held, DEPTH, sb.beats_checked);
    if (sb.fail_count == 0 && sb.expected_results_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.fail_count,
               sb.expected_results_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
